// File: sv/esor_pkg.sv
// ----------------------------------------------------------------------------
// esor_pkg: shared types and constants for the EMA smoother
// Digit size of the shared multiplier, gain width, register indexes and
// fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esor_pkg;

  // Operand digit taken by the shared multiplier in one cycle
  localparam int DIGIT_WIDTH = 32;
  // Q1.16 gain with room for exactly one (65536)
  localparam int GAIN_WIDTH = 17;
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WARMUP = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN = 4'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONFIRM = 4'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIMIT = 4'd3;

  localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = 17'd65536;
  localparam logic [GAIN_WIDTH-1:0] BLEND_GAIN = 17'd19661;
  localparam logic [GAIN_WIDTH-1:0] PCT_SCALE = 17'd25600;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

`default_nettype wire

// File: sv/esor_mul_unit.sv
// ----------------------------------------------------------------------------
// esor_mul_unit: digit-serial multiplier shared by the smoother
// Multiplies an unsigned operand by a 17-bit factor, one 32-bit digit of the
// operand per cycle, most significant digit first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esor_mul_unit #(
  parameter int XW = 47
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  input  wire [XW-1:0]                         x,
  input  wire [esor_pkg::GAIN_WIDTH-1:0]       m,
  output logic [XW+esor_pkg::GAIN_WIDTH-1:0]   product,
  output esor_pkg::mul_stat_t                  stat
);

  localparam int DW = esor_pkg::DIGIT_WIDTH;
  localparam int GW = esor_pkg::GAIN_WIDTH;
  localparam int PW = XW + GW;
  localparam int NDIG = (XW + DW - 1) / DW;
  localparam int XPW = NDIG * DW;
  localparam int CW = $clog2(NDIG + 1);

  logic [XPW-1:0]   xs;
  logic [GW-1:0]    mreg;
  logic [PW-1:0]    acc;
  logic [CW-1:0]    cnt;
  logic             done;
  logic [DW-1:0]    digit;
  logic [DW+GW-1:0] pp;
  logic [PW-1:0]    acc_next;

  assign digit = xs[XPW-1 -: DW];
  assign pp = digit * mreg;
  assign acc_next = (acc << DW) + PW'(pp);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs <= XPW'(x);
        mreg <= m;
        acc <= '0;
        cnt <= CW'(NDIG);
      end else if (cnt != '0) begin
        acc <= acc_next;
        xs <= xs << DW;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

// File: sv/ema_smoother_outlier_reject_core.sv
// ----------------------------------------------------------------------------
// ema_smoother_outlier_reject_core: EMA price smoother with outlier rejection
// One sample per item; a small sequencer runs the relative-change test and
// the average update through one shared digit-serial multiplier.
//
//   channel  signals                          direction  accepted when
//   in       in_valid/in_ready, sample        in         in_valid & in_ready
//   out      out_valid/out_ready, 8 fields    out        out_valid & out_ready
//   cfg      cfg_valid/cfg_ready, index/data  in         cfg_valid & cfg_ready
//
// An item runs k = 0..3 products through the shared multiplier, each
// of NDIG = ceil((SAMPLE_WIDTH-1)/32) digits, and one product at a time
// (two digits per product for 48-bit samples).
// in_ready is high only while the sequencer is idle. One output register
// holds a finished item, so a stalled output delays only the next load.
// Reset is synchronous; no clearing pass. cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ema_smoother_outlier_reject_core #(
  parameter int SAMPLE_WIDTH = 48
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire signed [SAMPLE_WIDTH-1:0]            sample,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]           raw_sample,
  output logic [SAMPLE_WIDTH-2:0]                  smoothed,
  output logic                                     anomaly_flag,
  output logic [esor_pkg::COUNT_WIDTH-1:0]         outlier_run,
  output logic                                     pending_flag,
  output logic                                     warmed_up,
  output logic [esor_pkg::COUNT_WIDTH-1:0]         accepted_count,
  output logic [SAMPLE_WIDTH-2:0]                  latest_stored,
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire [esor_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  wire [esor_pkg::GAIN_WIDTH-1:0]           cfg_data
);

  localparam int W = SAMPLE_WIDTH;
  localparam int GW = esor_pkg::GAIN_WIDTH;
  localparam int CNTW = esor_pkg::COUNT_WIDTH;
  localparam int PW = W - 1 + GW;

  localparam logic [PW-1:0] ROUND_UP = PW'(32768);
  localparam logic [PW-1:0] ROUND_DOWN = PW'(32767);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_FAR_A,
    S_FAR_B,
    S_UPD,
    S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [CNTW-1:0] warm;
  logic [GW-1:0]   gain;
  logic            confirm;
  logic [CNTW-1:0] limit;

  // smoother state
  logic [W-2:0]    ema;
  logic [CNTW-1:0] fill;
  logic            pend;
  logic [CNTW-1:0] ocnt;
  logic [W-2:0]    lastp;

  // item in flight
  logic signed [W-1:0] raw;
  logic                raw_ok;
  logic [W-2:0]        p_mag;
  logic [PW-1:0]       a_prod;
  logic [W-2:0]        res_smooth;
  logic                res_flag;
  logic [CNTW-1:0]     res_run;
  logic                upd_neg;
  logic                upd_report;

  // shared multiplier
  logic                mul_start;
  logic [W-2:0]        mul_x;
  logic [GW-1:0]       mul_m;
  logic [PW-1:0]       mul_product;
  esor_pkg::mul_stat_t mul_stat;

  logic            d_ge;
  logic [W-2:0]    d_abs;
  logic            far;
  logic [CNTW-1:0] ocnt_inc;
  logic [PW-1:0]   rnd;
  logic [W-1:0]    step;
  logic [W-2:0]    ema_upd;
  logic            out_load;

  esor_mul_unit #(
    .XW(W - 1)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_x),
    .m       (mul_m),
    .product (mul_product),
    .stat    (mul_stat)
  );

  assign d_ge = (p_mag >= ema);
  assign d_abs = d_ge ? (p_mag - ema) : (ema - p_mag);
  assign far = (a_prod > mul_product);
  assign ocnt_inc = (ocnt == {CNTW{1'b1}}) ? ocnt : ocnt + 1'b1;
  // round half up on the signed step: bias one less when the step is negative
  assign rnd = mul_product + (upd_neg ? ROUND_DOWN : ROUND_UP);
  assign step = rnd[PW-1:GW-1];
  assign ema_upd = upd_neg ? (ema - step[W-2:0]) : (ema + step[W-2:0]);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      warm <= CNTW'(20);
      gain <= GW'(13107);
      confirm <= 1'b1;
      limit <= CNTW'(1280);
      ema <= '0;
      fill <= '0;
      pend <= 1'b0;
      ocnt <= '0;
      lastp <= '0;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mul_start <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          esor_pkg::REG_WARMUP: begin
            warm <= cfg_data[CNTW-1:0];
          end
          esor_pkg::REG_GAIN: begin
            gain <= (cfg_data > esor_pkg::GAIN_ONE) ? esor_pkg::GAIN_ONE : cfg_data;
          end
          esor_pkg::REG_CONFIRM: begin
            confirm <= cfg_data[0];
          end
          esor_pkg::REG_LIMIT: begin
            limit <= cfg_data[CNTW-1:0];
          end
          default: begin
          end
        endcase
      end

      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw <= sample;
            raw_ok <= (sample != '0) && !sample[W-1];
            p_mag <= sample[W-2:0];
            res_flag <= 1'b0;
            res_run <= '0;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!raw_ok) begin
            res_smooth <= ema;
            state <= S_DONE;
          end else if (fill < warm) begin
            fill <= fill + 1'b1;
            lastp <= p_mag;
            res_smooth <= p_mag;
            if (fill == '0) begin
              ema <= p_mag;
              state <= S_DONE;
            end else begin
              mul_x <= d_abs;
              mul_m <= gain;
              upd_neg <= !d_ge;
              upd_report <= 1'b0;
              mul_start <= 1'b1;
              state <= S_UPD;
            end
          end else if (ema == '0) begin
            // a zero average never flags: take the normal update
            pend <= 1'b0;
            ocnt <= '0;
            mul_x <= d_abs;
            mul_m <= gain;
            upd_neg <= !d_ge;
            upd_report <= 1'b1;
            mul_start <= 1'b1;
            state <= S_UPD;
          end else begin
            mul_x <= d_abs;
            mul_m <= esor_pkg::PCT_SCALE;
            mul_start <= 1'b1;
            state <= S_FAR_A;
          end
        end
        S_FAR_A: begin
          if (mul_stat.done) begin
            a_prod <= mul_product;
            mul_x <= ema;
            mul_m <= GW'(limit);
            mul_start <= 1'b1;
            state <= S_FAR_B;
          end
        end
        S_FAR_B: begin
          if (mul_stat.done) begin
            if (far) begin
              ocnt <= ocnt_inc;
              res_flag <= 1'b1;
              res_run <= ocnt_inc;
              res_smooth <= ema;
              if (confirm && pend) begin
                mul_x <= d_abs;
                mul_m <= esor_pkg::BLEND_GAIN;
                upd_neg <= !d_ge;
                upd_report <= 1'b0;
                mul_start <= 1'b1;
                state <= S_UPD;
              end else begin
                if (confirm) begin
                  pend <= 1'b1;
                end
                state <= S_DONE;
              end
            end else begin
              pend <= 1'b0;
              ocnt <= '0;
              mul_x <= d_abs;
              mul_m <= gain;
              upd_neg <= !d_ge;
              upd_report <= 1'b1;
              mul_start <= 1'b1;
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (mul_stat.done) begin
            ema <= ema_upd;
            lastp <= p_mag;
            if (upd_report) begin
              res_smooth <= ema_upd;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_valid <= 1'b1;
            raw_sample <= raw;
            smoothed <= res_smooth;
            anomaly_flag <= res_flag;
            outlier_run <= res_run;
            pending_flag <= pend;
            warmed_up <= (fill >= warm);
            accepted_count <= fill;
            latest_stored <= lastp;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_pend_has_run: assert property (@(posedge clk) disable iff (rst)
    pend |-> (ocnt != '0))
    else $error("pending outlier without outlier count");

  a_seeded_average: assert property (@(posedge clk) disable iff (rst)
    (fill != '0) |-> (ema != '0))
    else $error("average is zero after seeding");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");
`endif

endmodule

`default_nettype wire

// File: test/tb_ema_smoother_outlier_reject_core.sv
// ----------------------------------------------------------------------------
// tb_ema_smoother_outlier_reject_core: self-checking bench for the EMA smoother
// Walks a short directed table (invalid prices, extremes, warm-up, confirm and
// reject modes, threshold extremes, register masking), then runs phases of
// random prices under changing register settings. Every result is checked
// field by field against a bit-exact predictor kept alongside the block, or the table's expected values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_ema_smoother_outlier_reject_core;

  localparam int GAIN_WIDTH = esor_pkg::GAIN_WIDTH;
  localparam int COUNT_WIDTH = esor_pkg::COUNT_WIDTH;
  localparam int CFG_INDEX_WIDTH = esor_pkg::CFG_INDEX_WIDTH;
  localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = esor_pkg::GAIN_ONE;
  localparam logic [GAIN_WIDTH-1:0] BLEND_GAIN = esor_pkg::BLEND_GAIN;
  localparam logic [GAIN_WIDTH-1:0] PCT_SCALE = esor_pkg::PCT_SCALE;

  localparam int SW = 48;
  localparam int ACC_W = SW + GAIN_WIDTH + 2;
  localparam int PROD_W = SW + GAIN_WIDTH;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WARMUP = esor_pkg::REG_WARMUP;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN = esor_pkg::REG_GAIN;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONFIRM = esor_pkg::REG_CONFIRM;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIMIT = esor_pkg::REG_LIMIT;

  localparam logic [SW-1:0] POS_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] NEG_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic [SW-1:0] raw;
    logic [SW-2:0] smoothed;
    logic anomaly;
    logic [COUNT_WIDTH-1:0] run;
    logic pending;
    logic warm;
    logic [COUNT_WIDTH-1:0] count;
    logic [SW-2:0] latest;
  } result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_INDEX_WIDTH-1:0] idx;
    logic [SW-1:0] value;
    logic typed;
    result_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [SW-1:0] sample;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SW-1:0] raw_sample;
  logic [SW-2:0] smoothed;
  logic anomaly_flag;
  logic [COUNT_WIDTH-1:0] outlier_run;
  logic pending_flag;
  logic warmed_up;
  logic [COUNT_WIDTH-1:0] accepted_count;
  logic [SW-2:0] latest_stored;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [GAIN_WIDTH-1:0] cfg_data;

  // predictor state and register copies
  logic [SW-1:0] ema_acc;
  logic [COUNT_WIDTH-1:0] fill_cnt;
  logic anomaly_hold;
  logic [COUNT_WIDTH-1:0] run_cnt;
  logic [SW-1:0] last_store;
  logic [COUNT_WIDTH-1:0] warm_len;
  logic [GAIN_WIDTH-1:0] gain_q16;
  logic confirm_on;
  logic [15:0] limit_q8;

  result_t due_results[$];
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int stall_left = 0;
  logic quiet_tail = 1'b0;

  ema_smoother_outlier_reject_core #(
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .raw_sample(raw_sample),
    .smoothed(smoothed),
    .anomaly_flag(anomaly_flag),
    .outlier_run(outlier_run),
    .pending_flag(pending_flag),
    .warmed_up(warmed_up),
    .accepted_count(accepted_count),
    .latest_stored(latest_stored),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SW-1:0] q16(input int unsigned whole);
    return SW'(whole) << 16;
  endfunction

  // (g*new + (one-g)*old) / one, halves rounded up
  function automatic logic [SW-1:0] weighted_mean(input logic [GAIN_WIDTH-1:0] g,
                                                 input logic [SW-1:0] nv,
                                                 input logic [SW-1:0] ov);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(g) * ACC_W'(nv) + ACC_W'(GAIN_ONE - g) * ACC_W'(ov)
        + ACC_W'(GAIN_ONE >> 1);
    return acc[SW+15:16];
  endfunction

  // |p - r| * 100 > r * limit / 256, by cross-multiplication
  function automatic logic far_from_mean(input logic [SW-1:0] p, input logic [SW-1:0] r);
    logic [SW-1:0] d;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    if (r == '0) return 1'b0;
    d = (p > r) ? p - r : r - p;
    lhs = PROD_W'(d) * PROD_W'(PCT_SCALE);
    rhs = PROD_W'(r) * PROD_W'(limit_q8);
    return lhs > rhs;
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                         input logic [GAIN_WIDTH-1:0] data);
    case (idx)
      REG_WARMUP: warm_len = data[15:0];
      REG_GAIN: gain_q16 = (data > GAIN_ONE) ? GAIN_ONE : data;
      REG_CONFIRM: confirm_on = data[0];
      REG_LIMIT: limit_q8 = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic result_t predict_smoothing(input logic [SW-1:0] s);
    result_t res;
    res = '0;
    res.raw = s;
    res.smoothed = ema_acc[SW-2:0];
    if (s != '0 && !s[SW-1]) begin
      if (fill_cnt < warm_len) begin
        fill_cnt = fill_cnt + 1'b1;
        ema_acc = (fill_cnt == 1) ? s : weighted_mean(gain_q16, s, ema_acc);
        last_store = s;
        res.smoothed = s[SW-2:0];
      end else if (far_from_mean(s, ema_acc)) begin
        if (run_cnt != '1) run_cnt = run_cnt + 1'b1;
        res.run = run_cnt;
        res.anomaly = 1'b1;
        res.smoothed = ema_acc[SW-2:0];
        if (confirm_on) begin
          if (!anomaly_hold) begin
            anomaly_hold = 1'b1;
          end else begin
            ema_acc = weighted_mean(BLEND_GAIN, s, ema_acc);
            last_store = s;
          end
        end
      end else begin
        anomaly_hold = 1'b0;
        run_cnt = '0;
        ema_acc = weighted_mean(gain_q16, s, ema_acc);
        last_store = s;
        res.smoothed = ema_acc[SW-2:0];
      end
    end
    res.pending = anomaly_hold;
    res.warm = fill_cnt >= warm_len;
    res.count = fill_cnt;
    res.latest = last_store[SW-2:0];
    return res;
  endfunction

  // keep a candidate price if it is in the valid range, else use the fallback
  function automatic logic [SW-1:0] keep_valid(input logic [63:0] t, input logic [SW-1:0] fb);
    if (t == 0 || t > 64'(POS_MAX)) return fb;
    return t[SW-1:0];
  endfunction

  function automatic result_t quiet_result(input logic [SW-1:0] raw, input logic [SW-2:0] sm,
                                           input logic warm,
                                           input logic [COUNT_WIDTH-1:0] cnt,
                                           input logic [SW-2:0] latest);
    result_t r;
    r = '0;
    r.raw = raw;
    r.smoothed = sm;
    r.warm = warm;
    r.count = cnt;
    r.latest = latest;
    return r;
  endfunction

  function automatic stim_row_t row_sample(input logic [SW-1:0] s);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.idx = '0;
    r.value = s;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t row_typed(input logic [SW-1:0] s, input result_t want);
    stim_row_t r;
    r = row_sample(s);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t row_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                          input logic [GAIN_WIDTH-1:0] data);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.value = SW'(data);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("error: result %0d field %s got %h want %h", results_seen, field, got, want);
  endtask

  // hold valid until the item is taken, then log its expected result
  task automatic push_sample(input logic [SW-1:0] s, input logic typed, input result_t want);
    result_t predicted;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    predicted = predict_smoothing(s);
    due_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [GAIN_WIDTH-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // output side: random stall bursts, none in the tail
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected", 64'(raw_sample), 64'd0);
      end else begin
        want = due_results.pop_front();
        if (raw_sample !== want.raw) report_mismatch("raw_sample", 64'(raw_sample), 64'(want.raw));
        if (smoothed !== want.smoothed)
          report_mismatch("smoothed", 64'(smoothed), 64'(want.smoothed));
        if (anomaly_flag !== want.anomaly)
          report_mismatch("anomaly_flag", 64'(anomaly_flag), 64'(want.anomaly));
        if (outlier_run !== want.run)
          report_mismatch("outlier_run", 64'(outlier_run), 64'(want.run));
        if (pending_flag !== want.pending)
          report_mismatch("pending_flag", 64'(pending_flag), 64'(want.pending));
        if (warmed_up !== want.warm)
          report_mismatch("warmed_up", 64'(warmed_up), 64'(want.warm));
        if (accepted_count !== want.count)
          report_mismatch("accepted_count", 64'(accepted_count), 64'(want.count));
        if (latest_stored !== want.latest)
          report_mismatch("latest_stored", 64'(latest_stored), 64'(want.latest));
      end
      results_seen++;
    end
  end

  // watchdog: end the run when no channel moves an item for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    stim_row_t plan[$];
    logic [SW-1:0] center;
    logic [SW-1:0] span;
    logic [SW-1:0] burst_val;
    logic [SW-1:0] s;
    logic [63:0] t;
    logic [63:0] delta;
    logic [GAIN_WIDTH-1:0] wl;
    logic [GAIN_WIDTH-1:0] gn;
    logic [GAIN_WIDTH-1:0] lim;
    int pick;
    int burst_left;
    int k;

    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ema_acc = '0;
    fill_cnt = '0;
    anomaly_hold = 1'b0;
    run_cnt = '0;
    last_store = '0;
    warm_len = COUNT_WIDTH'(20);
    gain_q16 = GAIN_WIDTH'(13107);
    confirm_on = 1'b1;
    limit_q8 = 16'd1280;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // invalid prices after reset report the zero average
    plan.push_back(row_typed('0, quiet_result('0, '0, 1'b0, '0, '0)));
    plan.push_back(row_typed(NEG_MIN, quiet_result(NEG_MIN, '0, 1'b0, '0, '0)));
    plan.push_back(row_typed('1, quiet_result('1, '0, 1'b0, '0, '0)));
    // zero warm-up: zero average never flags
    plan.push_back(row_write(REG_WARMUP, 17'd0));
    plan.push_back(row_sample(q16(100)));
    plan.push_back(row_sample(q16(20)));
    // warm-up again: first stored price seeds the average
    plan.push_back(row_write(REG_WARMUP, 17'd3));
    plan.push_back(row_typed(POS_MAX, quiet_result(POS_MAX, POS_MAX[SW-2:0], 1'b0,
                                                   COUNT_WIDTH'(1), POS_MAX[SW-2:0])));
    plan.push_back(row_sample(SW'(1)));
    // gain write above one saturates
    plan.push_back(row_write(REG_GAIN, 17'h1FFFF));
    plan.push_back(row_sample(q16(100)));
    plan.push_back(row_sample(q16(100)));
    // confirm mode: pend, then blend
    plan.push_back(row_sample(q16(200)));
    plan.push_back(row_sample(q16(200)));
    plan.push_back(row_sample('0));
    plan.push_back(row_sample(q16(200)));
    plan.push_back(row_sample(q16(150)));
    // reject mode
    plan.push_back(row_write(REG_CONFIRM, 17'd0));
    plan.push_back(row_sample(q16(400)));
    plan.push_back(row_sample(q16(400)));
    plan.push_back(row_sample(q16(150)));
    // zero threshold and zero gain
    plan.push_back(row_write(REG_LIMIT, 17'd0));
    plan.push_back(row_write(REG_GAIN, 17'd0));
    plan.push_back(row_sample(q16(150) + 1));
    // widest threshold, warm-up cut below the count
    plan.push_back(row_write(REG_LIMIT, 17'h0FFFF));
    plan.push_back(row_write(REG_CONFIRM, 17'd1));
    plan.push_back(row_write(REG_WARMUP, 17'd1));
    plan.push_back(row_sample(POS_MAX));
    plan.push_back(row_sample(SW'(1)));
    // writes to unused indexes are dropped
    plan.push_back(row_write('1, 17'h1FFFF));
    plan.push_back(row_sample(q16(150)));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE)
        cfg_write(plan[i].idx, plan[i].value[GAIN_WIDTH-1:0]);
      else
        push_sample(plan[i].value, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wl = (ph == 3) ? 17'h1FFFF : (ph == 5) ? 17'd0 : GAIN_WIDTH'($urandom_range(1, 12));
      gn = (ph == 1) ? 17'd0 : (ph == 2) ? 17'h1FFFF : (ph == 4) ? GAIN_ONE :
           GAIN_WIDTH'($urandom_range(0, 65536));
      lim = (ph == 2) ? 17'h0FFFF : (ph == 4) ? 17'd0 : GAIN_WIDTH'($urandom_range(64, 6400));
      cfg_write(REG_WARMUP, wl);
      cfg_write(REG_GAIN, gn);
      cfg_write(REG_CONFIRM, (ph == 0) ? 17'd1 : (ph == 1) ? 17'd0 :
                GAIN_WIDTH'($urandom_range(0, 1)));
      cfg_write(REG_LIMIT, lim);
      if (ph == 6)
        cfg_write(CFG_INDEX_WIDTH'($urandom_range(REG_LIMIT + 1, (1 << CFG_INDEX_WIDTH) - 1)),
                  GAIN_WIDTH'($urandom));
      quiet_tail = (ph == PHASES - 1);
      burst_left = 0;
      burst_val = '0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        center = (ema_acc == '0) ? q16($urandom_range(1, 5000)) : ema_acc;
        pick = $urandom_range(0, 99);
        if (burst_left > 0) begin
          t = 64'(burst_val);
          burst_left--;
        end else if (pick < 45) begin
          span = center >> $urandom_range(3, 14);
          delta = {$urandom, $urandom} % (64'(span) + 1);
          t = $urandom_range(0, 1) ? 64'(center) + delta : 64'(center) - delta;
          t = 64'(keep_valid(t, center));
        end else if (pick < 60) begin
          // straddle the outlier threshold by one step
          delta = 64'((PROD_W'(center) * PROD_W'(limit_q8)) / PROD_W'(PCT_SCALE));
          t = $urandom_range(0, 1) ? 64'(center) + delta : 64'(center) - delta;
          t = t + 64'($urandom_range(0, 2)) - 1;
          t = 64'(keep_valid(t, center));
        end else if (pick < 76) begin
          k = $urandom_range(1, 3);
          t = $urandom_range(0, 1) ? 64'(center) << k : 64'(center) >> k;
          if (t == 0) t = 64'd1;
          if (t > 64'(POS_MAX)) t = 64'(POS_MAX);
          // start a run of repeated outliers
          if (pick >= 70) begin
            burst_val = t[SW-1:0];
            burst_left = $urandom_range(1, 6);
          end
        end else if (pick < 84) begin
          case ($urandom_range(0, 2))
            0: t = '0;
            1: t = 64'(NEG_MIN);
            default: t = {$urandom, $urandom} | 64'(NEG_MIN);
          endcase
        end else if (pick < 89) begin
          t = 64'($urandom_range(1, 255));
        end else if (pick < 93) begin
          t = 64'(POS_MAX) - 64'($urandom_range(0, 255));
        end else begin
          t = {$urandom, $urandom};
        end
        s = t[SW-1:0];
        push_sample(s, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0) report_mismatch("leftover", 64'(due_results.size()), 64'd0);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/esor_pkg.sv
sv/esor_mul_unit.sv
sv/ema_smoother_outlier_reject_core.sv
test/tb_ema_smoother_outlier_reject_core.sv
